// ===== hdl/bbc_pkg.sv =====
`default_nettype none
package bbc_pkg;

  // Default size of the buffer pool.
  localparam int NUM_BUFFERS_DEF = 16;

  // Widths fixed by the item fields.
  localparam int CMD_W  = 3;
  localparam int TAG_W  = 32;
  localparam int IDX_W  = 4;
  localparam int SLOT_W = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } bbc_state_t;

  // Per-buffer status bits.
  typedef struct packed {
    logic valid;
    logic done;
    logic dirty;
  } bbc_flags_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic look;    // compare the held item against the cell
    logic by_tag;  // compare by block tag rather than by slot number
    logic apply;   // commit the update this cycle
    logic move;    // the target moves to the most recent end
    logic load;    // the target is rewritten in place
  } bbc_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/bbc_cell.sv =====
`default_nettype none
module bbc_cell #(
  parameter int SW  = 4,
  parameter int IW  = 4,
  parameter int POS = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bbc_pkg::bbc_ctl_t        ctl,
  input  wire logic [bbc_pkg::TAG_W-1:0] blk,
  input  wire logic [IW-1:0]            idx,
  // Record offered by the next more recent cell, or the new record at the top.
  input  wire logic [SW-1:0]            nb_id,
  input  wire logic [bbc_pkg::TAG_W-1:0] nb_tag,
  input  wire bbc_pkg::bbc_flags_t      nb_flg,
  // Record to write when the target is updated in place.
  input  wire logic [bbc_pkg::TAG_W-1:0] new_tag,
  input  wire bbc_pkg::bbc_flags_t      new_flg,
  input  wire logic                     seen_i,
  output logic                          seen_o,
  output logic                          match,
  output logic [SW-1:0]                 id,
  output logic [bbc_pkg::TAG_W-1:0]     tag,
  output bbc_pkg::bbc_flags_t           flg
);

  logic [SW-1:0]             id_r;
  logic [bbc_pkg::TAG_W-1:0] tag_r;
  bbc_pkg::bbc_flags_t       flg_r;
  logic                      match_r;
  logic                      match_nxt;
  logic                      shift;
  logic                      load;

  // Compare against the held item, by tag for lookups or by slot number.
  always_comb begin
    if (ctl.by_tag) begin
      match_nxt = flg_r.valid && (tag_r == blk);
    end else begin
      match_nxt = (IW'(id_r) == idx);
    end
  end

  // The target and every cell above it take their neighbour's record on a move.
  assign seen_o = seen_i | match_r;
  assign shift  = ctl.apply & ctl.move & seen_o;
  assign load   = ctl.apply & ctl.load & match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r    <= SW'(POS);
      flg_r   <= '0;
      match_r <= 1'b0;
    end else begin
      if (ctl.look) begin
        match_r <= match_nxt;
      end
      if (shift) begin
        id_r  <= nb_id;
        flg_r <= nb_flg;
      end else if (load) begin
        flg_r <= new_flg;
      end
    end
  end

  // The tag needs no reset: it is only looked at where the valid bit is set.
  always_ff @(posedge clk) begin
    if (shift) begin
      tag_r <= nb_tag;
    end else if (load) begin
      tag_r <= new_tag;
    end
  end

  assign match = match_r;
  assign id    = id_r;
  assign tag   = tag_r;
  assign flg   = flg_r;

endmodule
`default_nettype wire

// ===== hdl/block_buffer_cache_policy.sv =====
// Buffer cache replacement controller.
// Input channel (in_valid / in_stall) takes one command item: cmd, block_number
// and buffer_index. Result channel (out_valid / out_stall) gives one result item
// per command: slot, hit, fill_request, writeback_request, writeback_block.
// The pool is a row of cells ordered from least recent (cell 0) to most recent.
// Each item passes the idle state, where it is accepted, the look state, where
// every cell compares itself against the item, and the apply state, where the
// result is formed and, for a moving command, the cells shift towards the least
// recent end to move the target to the most recent cell. A new item is accepted
// only after the last one commits; in_stall is high while an item is at work.
// A committed result waits in the output register while out_stall is high; the
// next item is still accepted and looked up, and it commits only once the output
// register is free. Reset is synchronous: it clears all status bits, puts slot p
// in cell p and empties the output register. Tags are not cleared.
`default_nettype none
module block_buffer_cache_policy #(
  parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bbc_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [bbc_pkg::TAG_W-1:0]  in_block_number,
  input  wire logic [bbc_pkg::IDX_W-1:0]  in_buffer_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bbc_pkg::SLOT_W-1:0]      out_slot,
  output logic                            out_hit,
  output logic                            out_fill_request,
  output logic                            out_writeback_request,
  output logic [bbc_pkg::TAG_W-1:0]       out_writeback_block
);

  localparam int SW = $clog2(NUM_BUFFERS);
  localparam int IW = (SW > bbc_pkg::IDX_W) ? SW : bbc_pkg::IDX_W;

  bbc_pkg::bbc_state_t state_r, state_nxt;

  logic [bbc_pkg::CMD_W-1:0] cmd_r;
  logic [bbc_pkg::TAG_W-1:0] blk_r;
  logic [bbc_pkg::IDX_W-1:0] idx_r;

  bbc_pkg::bbc_ctl_t ctl;

  // Cell outputs.
  logic [SW-1:0]             c_id   [NUM_BUFFERS];
  logic [bbc_pkg::TAG_W-1:0] c_tag  [NUM_BUFFERS];
  bbc_pkg::bbc_flags_t       c_flg  [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]    c_match;
  logic [NUM_BUFFERS:0]      c_seen;

  // Selected record and the record written back into the row.
  logic [SW-1:0]             cur_id;
  logic [bbc_pkg::TAG_W-1:0] cur_tag;
  bbc_pkg::bbc_flags_t       cur_flg;
  logic [bbc_pkg::TAG_W-1:0] new_tag;
  bbc_pkg::bbc_flags_t       new_flg;
  logic                      any_match;
  logic                      by_tag;
  logic                      miss;
  logic                      move;
  logic                      load;
  logic [IW-1:0]             cur_id_ext;

  // Result fields.
  logic [bbc_pkg::SLOT_W-1:0] res_slot;
  logic                       res_hit;
  logic                       res_fill;
  logic                       res_wb;
  logic [bbc_pkg::TAG_W-1:0]  res_wb_blk;

  // Output register.
  logic                       out_valid_r;
  logic [bbc_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_hit_r;
  logic                       out_fill_r;
  logic                       out_wb_r;
  logic [bbc_pkg::TAG_W-1:0]  out_wb_blk_r;
  logic                       out_free;
  logic                       commit;

  assign in_stall = (state_r != bbc_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign by_tag   = (cmd_r == bbc_pkg::CMD_READ) || (cmd_r == bbc_pkg::CMD_GET);

  // Hold the accepted item.
  always_ff @(posedge clk) begin
    if ((state_r == bbc_pkg::ST_IDLE) && in_valid) begin
      cmd_r <= in_cmd;
      blk_r <= in_block_number;
      idx_r <= in_buffer_index;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and cell control.
  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    case (state_r)
      bbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bbc_pkg::ST_LOOK;
        end
      end
      bbc_pkg::ST_LOOK: begin
        state_nxt = bbc_pkg::ST_APPLY;
      end
      bbc_pkg::ST_APPLY: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = bbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbc_pkg::ST_IDLE;
      end
    endcase
    ctl.look   = (state_r == bbc_pkg::ST_LOOK);
    ctl.by_tag = by_tag;
    ctl.apply  = commit;
    ctl.move   = move;
    ctl.load   = load;
  end

  // Row of cells, least recent first.
  assign c_seen[0] = miss;

  for (genvar k = 0; k < NUM_BUFFERS; k++) begin : g_cell
    logic [SW-1:0]             nb_id;
    logic [bbc_pkg::TAG_W-1:0] nb_tag;
    bbc_pkg::bbc_flags_t       nb_flg;

    if (k == NUM_BUFFERS - 1) begin : g_top
      assign nb_id  = cur_id;
      assign nb_tag = new_tag;
      assign nb_flg = new_flg;
    end else begin : g_mid
      assign nb_id  = c_id[k+1];
      assign nb_tag = c_tag[k+1];
      assign nb_flg = c_flg[k+1];
    end

    bbc_cell #(
      .SW  (SW),
      .IW  (IW),
      .POS (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .blk     (blk_r),
      .idx     (IW'(idx_r)),
      .nb_id   (nb_id),
      .nb_tag  (nb_tag),
      .nb_flg  (nb_flg),
      .new_tag (new_tag),
      .new_flg (new_flg),
      .seen_i  (c_seen[k]),
      .seen_o  (c_seen[k+1]),
      .match   (c_match[k]),
      .id      (c_id[k]),
      .tag     (c_tag[k]),
      .flg     (c_flg[k])
    );
  end

  // Pick the matching cell, or the least recent one on a lookup miss.
  always_comb begin
    any_match = |c_match;
    miss      = by_tag && !any_match;
    cur_id    = '0;
    cur_tag   = '0;
    cur_flg   = '0;
    if (miss) begin
      cur_id  = c_id[0];
      cur_tag = c_tag[0];
      cur_flg = c_flg[0];
    end else begin
      for (int k = 0; k < NUM_BUFFERS; k++) begin
        if (c_match[k]) begin
          cur_id  = cur_id | c_id[k];
          cur_tag = cur_tag | c_tag[k];
          cur_flg = cur_flg | c_flg[k];
        end
      end
    end
  end

  assign cur_id_ext = IW'(cur_id);

  // Form the result and the updated record for the target.
  always_comb begin
    new_tag    = cur_tag;
    new_flg    = cur_flg;
    move       = 1'b0;
    load       = 1'b0;
    res_slot   = idx_r;
    res_hit    = 1'b0;
    res_fill   = 1'b0;
    res_wb     = 1'b0;
    case (cmd_r)
      bbc_pkg::CMD_READ, bbc_pkg::CMD_GET: begin
        res_slot = cur_id_ext[bbc_pkg::SLOT_W-1:0];
        move     = 1'b1;
        if (any_match) begin
          res_hit = 1'b1;
        end else begin
          // Evict the least recent buffer, writing it back if dirty.
          res_wb        = cur_flg.dirty && cur_flg.valid;
          new_tag       = blk_r;
          new_flg.valid = 1'b1;
          new_flg.done  = 1'b0;
          new_flg.dirty = 1'b0;
        end
        if ((cmd_r == bbc_pkg::CMD_READ) && !new_flg.done) begin
          res_fill     = 1'b1;
          new_flg.done = 1'b1;
        end
      end
      bbc_pkg::CMD_MARK: begin
        if (any_match && cur_flg.valid) begin
          new_flg.dirty = 1'b1;
          load          = 1'b1;
        end
      end
      bbc_pkg::CMD_RELEASE: begin
        if (any_match) begin
          res_wb        = cur_flg.dirty && cur_flg.valid;
          new_flg.dirty = 1'b0;
          move          = 1'b1;
        end
      end
      bbc_pkg::CMD_WRITE: begin
        if (any_match && cur_flg.valid) begin
          res_wb        = 1'b1;
          new_flg.dirty = 1'b0;
          new_flg.done  = 1'b1;
          move          = 1'b1;
        end
      end
      default: begin
        res_slot = '0;
      end
    endcase
    res_wb_blk = res_wb ? cur_tag : '0;
  end

  // Output register; it frees in the cycle its item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_slot_r   <= res_slot;
      out_hit_r    <= res_hit;
      out_fill_r   <= res_fill;
      out_wb_r     <= res_wb;
      out_wb_blk_r <= res_wb_blk;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_slot              = out_slot_r;
  assign out_hit               = out_hit_r;
  assign out_fill_request      = out_fill_r;
  assign out_writeback_request = out_wb_r;
  assign out_writeback_block   = out_wb_blk_r;

endmodule
`default_nettype wire

// ===== hdl/bbc_checker.sv =====
`default_nettype none
module bbc_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bbc_pkg::SLOT_W-1:0] out_slot,
  input wire logic                       out_hit,
  input wire logic                       out_writeback_request,
  input wire logic [bbc_pkg::TAG_W-1:0]  out_writeback_block
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_hit)
      && $stable(out_writeback_block))
    else $error("result item changed while stalled");

  // Only one item is at work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("item accepted while another was at work");

  // A hit never evicts, so it never asks for a write-back.
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_writeback_request)
    else $error("write-back requested on a hit");

  // A result register that was empty fills only from an item that was accepted and passed the look and apply states.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 3))
    else $error("result item without a matching accepted item");

endmodule

bind block_buffer_cache_policy bbc_checker u_bbc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_slot              (out_slot),
  .out_hit               (out_hit),
  .out_writeback_request (out_writeback_request),
  .out_writeback_block   (out_writeback_block)
);
`default_nettype wire
